FILE: sv/mseu_pkg.sv
package mseu_pkg;

   localparam int MemBytesDefault = 65536;
   localparam int RegCount = 32;
   localparam int RegIdxW = 5;
   localparam int CsrIdxW = 2;

   localparam logic [31:0] JumpRegionMask = 32'hF000_0000;
   localparam logic [31:0] ExitCode = 32'd10;

   typedef enum logic [4:0] {
      OP_NOOP = 5'd0, OP_ADD = 5'd1, OP_ADDI = 5'd2, OP_ADDIU = 5'd3,
      OP_ADDU = 5'd4, OP_SUB = 5'd5, OP_DIV = 5'd6, OP_MULT = 5'd7,
      OP_J = 5'd8, OP_SYSCALL = 5'd9, OP_ORI = 5'd10, OP_AND = 5'd11,
      OP_BEQ = 5'd12, OP_MFHI = 5'd13, OP_MFLO = 5'd14, OP_LUI = 5'd15,
      OP_LB = 5'd16, OP_SB = 5'd17, OP_LW = 5'd18, OP_SW = 5'd19
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_TERM = 2'd1, ST_UNSUP = 2'd2, ST_BADSYS = 2'd3
   } status_type;

   localparam logic [CsrIdxW-1:0] CSR_START_PC = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_SP_INIT = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_GP_INIT = 2'd2;
   localparam logic [RegIdxW-1:0] REG_SP = 5'd29;
   localparam logic [RegIdxW-1:0] REG_GP = 5'd28;
   localparam logic [RegIdxW-1:0] REG_V0 = 5'd2;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EXEC, S_MEM, S_DIV, S_DONE
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load_item;   // capture the input word
      logic read_regs;   // register the operands
      logic exec;        // first execute cycle
      logic mem_step;    // one memory byte step
      logic div_start;
      logic div_step;
      logic finish;      // commit and load the result register
   } cmd_type;

   typedef struct packed {
      logic is_mem;      // item needs byte steps
      logic is_div;
      logic mem_last;
      logic div_last;
   } stat_type;

endpackage

FILE: sv/mseu_ctrl.sv
module mseu_ctrl
   import mseu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      out_full_ff, out_full_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_full_ff <= out_full_in;
      end
   end

   assign rsp_tvalid = out_full_ff;
   // A new word is taken while the previous result still waits, but its
   // commit waits for the output register to drain.
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      out_full_in = out_full_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.read_regs = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.is_mem) state_in = S_MEM;
            else if (stat.is_div) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else state_in = S_DONE;
         end
         S_MEM: begin
            cmd.mem_step = 1'b1;
            if (stat.mem_last) state_in = S_DONE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (!out_full_in) begin
               cmd.finish = 1'b1;
               out_full_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(out_full_ff && !rsp_tready))
      else $error("result overwrote a pending word");
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_tvalid)
      else $error("finished item not shown");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> stat.is_div)
      else $error("divide state without divide");

endmodule

FILE: sv/mseu_datapath.sv
module mseu_datapath
   import mseu_pkg::*;
#(
   parameter int MemBytes = MemBytesDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic [63:0]          req_word,
   input  logic                 csr_we,
   input  logic [CsrIdxW-1:0]   csr_index,
   input  logic [31:0]          csr_wdata,
   output logic [71:0]          rsp_word
);

   localparam int AddrW = $clog2(MemBytes);

   logic [RegIdxW-1:0] rs_idx, rt_idx, rd_idx;
   logic [15:0] imm;
   logic [25:0] tgt;
   op_type op;
   logic [63:0] item_ff;

   always_ff @(posedge clock) if (cmd.load_item) item_ff <= req_word;
   assign op     = op_type'(item_ff[4:0]);
   assign rs_idx = item_ff[9:5];
   assign rt_idx = item_ff[14:10];
   assign rd_idx = item_ff[19:15];
   assign imm    = item_ff[35:20];
   assign tgt    = item_ff[61:36];

   logic [31:0] simm;
   assign simm = {{16{imm[15]}}, imm};

   // Register file: read in the read cycle, one write port.
   logic [31:0] regs [RegCount];
   logic [31:0] rs_ff, rt_ff, v0_ff;
   logic        rf_we;
   logic [RegIdxW-1:0] rf_widx;
   logic [31:0] rf_wval;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RegCount; i++) regs[i] <= '0;
      end else if (csr_we && csr_index == CSR_SP_INIT) begin
         regs[REG_SP] <= csr_wdata;
      end else if (csr_we && csr_index == CSR_GP_INIT) begin
         regs[REG_GP] <= csr_wdata;
      end else if (rf_we) begin
         regs[rf_widx] <= rf_wval;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_regs) begin
         rs_ff <= (rs_idx == '0) ? '0 : regs[rs_idx];
         rt_ff <= (rt_idx == '0) ? '0 : regs[rt_idx];
         v0_ff <= regs[REG_V0];
      end
   end

   logic [31:0] pc_ff, hi_ff, lo_ff;
   logic [31:0] addr_ff, res_ff, npc_ff;
   logic [1:0]  status_ff;
   logic        wr_ff;
   logic [RegIdxW-1:0] widx_ff;
   logic [1:0]  byte_ff;
   logic [63:0] prod_ff;
   logic        mult_ff;
   logic        lw_done_ff;

   // Byte memory, one access per cycle.
   logic [7:0] mem [MemBytes];
   logic [AddrW-1:0] maddr;
   logic [7:0] mrd_ff;
   logic       mwe;
   logic [7:0] mwd;
   logic       rd_pend_ff;
   logic [31:0] pc4;

   assign pc4   = pc_ff + 32'd4;
   assign maddr = AddrW'(addr_ff + {30'd0, byte_ff});
   assign mwe   = cmd.mem_step && (op == OP_SB || op == OP_SW);
   assign mwd   = (op == OP_SB) ? rt_ff[7:0] : rt_ff[8*(3-byte_ff) +: 8];

   always_ff @(posedge clock) begin
      if (mwe) mem[maddr] <= mwd;
      mrd_ff <= mem[maddr];
   end

   // Divider: restoring, one quotient bit per cycle on magnitudes.
   logic [31:0] dq_ff, dr_ff, dd_ff;
   logic [5:0]  dcnt_ff;
   logic        dna_ff, dnb_ff, dz_ff;
   logic [32:0] trial;
   assign trial = {dr_ff, dq_ff[31]} - {1'b0, dd_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dna_ff <= rs_ff[31];
         dnb_ff <= rt_ff[31];
         dz_ff <= (rt_ff == '0);
         dq_ff <= rs_ff[31] ? -rs_ff : rs_ff;
         dd_ff <= rt_ff[31] ? -rt_ff : rt_ff;
         dr_ff <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (!trial[32]) begin
            dr_ff <= trial[31:0];
            dq_ff <= {dq_ff[30:0], 1'b1};
         end else begin
            dr_ff <= {dr_ff[30:0], dq_ff[31]};
            dq_ff <= {dq_ff[30:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 6'd1;
      end
   end

   assign stat.is_mem  = (op == OP_LB || op == OP_SB || op == OP_LW || op == OP_SW);
   assign stat.is_div  = (op == OP_DIV);
   assign stat.div_last = (dcnt_ff == 6'd31);
   // A load needs one extra step so the last byte read lands.
   assign stat.mem_last = (op == OP_SB) ? 1'b1 :
                          (op == OP_LB) ? rd_pend_ff :
                          (op == OP_SW) ? (byte_ff == 2'd3) :
                          (rd_pend_ff && byte_ff == 2'd0 && lw_done_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
         hi_ff <= '0;
         lo_ff <= '0;
      end else begin
         if (csr_we && csr_index == CSR_START_PC) pc_ff <= csr_wdata;
         else if (cmd.finish) pc_ff <= npc_ff;
         if (mult_ff && cmd.finish) begin
            hi_ff <= prod_ff[63:32];
            lo_ff <= prod_ff[31:0];
         end else if (cmd.div_step && stat.div_last && !dz_ff) begin
            lo_ff <= (dna_ff != dnb_ff) ? -(trial[32] ? {dq_ff[30:0],1'b0}
                                                     : {dq_ff[30:0],1'b1})
                                        : (trial[32] ? {dq_ff[30:0],1'b0}
                                                     : {dq_ff[30:0],1'b1});
            hi_ff <= dna_ff ? -(trial[32] ? {dr_ff[30:0],dq_ff[31]} : trial[31:0])
                            : (trial[32] ? {dr_ff[30:0],dq_ff[31]} : trial[31:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         addr_ff <= rs_ff + simm;
         byte_ff <= '0;
         rd_pend_ff <= 1'b0;
         lw_done_ff <= 1'b0;
         npc_ff <= pc4;
         status_ff <= ST_OK;
         wr_ff <= 1'b0;
         widx_ff <= '0;
         res_ff <= '0;
         mult_ff <= (op == OP_MULT);
         prod_ff <= 64'($signed(rs_ff) * $signed(rt_ff));
         case (op)
            OP_NOOP, OP_DIV, OP_MULT, OP_SB, OP_SW: ;
            OP_ADD, OP_ADDU: begin
               wr_ff <= 1'b1; widx_ff <= rd_idx; res_ff <= rs_ff + rt_ff;
            end
            OP_ADDI, OP_ADDIU: begin
               wr_ff <= 1'b1; widx_ff <= rt_idx; res_ff <= rs_ff + simm;
            end
            OP_SUB: begin
               wr_ff <= 1'b1; widx_ff <= rd_idx; res_ff <= rs_ff - rt_ff;
            end
            OP_J: npc_ff <= (pc4 & JumpRegionMask) | {4'd0, tgt, 2'd0};
            OP_SYSCALL: begin
               if (v0_ff == ExitCode) begin
                  status_ff <= ST_TERM; npc_ff <= pc_ff;
               end else status_ff <= ST_BADSYS;
            end
            OP_ORI: begin
               wr_ff <= 1'b1; widx_ff <= rt_idx; res_ff <= rs_ff | {16'd0, imm};
            end
            OP_AND: begin
               wr_ff <= 1'b1; widx_ff <= rd_idx; res_ff <= rs_ff & rt_ff;
            end
            OP_BEQ: if (rs_ff == rt_ff) npc_ff <= pc4 + {simm[29:0], 2'b00};
            OP_MFHI: begin
               wr_ff <= 1'b1; widx_ff <= rd_idx; res_ff <= hi_ff;
            end
            OP_MFLO: begin
               wr_ff <= 1'b1; widx_ff <= rd_idx; res_ff <= lo_ff;
            end
            OP_LUI: begin
               wr_ff <= 1'b1; widx_ff <= rt_idx; res_ff <= {imm, 16'd0};
            end
            OP_LB, OP_LW: begin
               wr_ff <= 1'b1; widx_ff <= rt_idx;
            end
            default: begin
               status_ff <= ST_UNSUP; npc_ff <= pc_ff;
            end
         endcase
      end else if (cmd.mem_step) begin
         rd_pend_ff <= 1'b1;
         if (op == OP_LB && rd_pend_ff) res_ff <= {{24{mrd_ff[7]}}, mrd_ff};
         if (op == OP_LW) begin
            if (rd_pend_ff) res_ff <= {res_ff[23:0], mrd_ff};
            if (byte_ff == 2'd3) lw_done_ff <= 1'b1;
            if (!lw_done_ff) byte_ff <= byte_ff + 2'd1;
         end
         if (op == OP_SW) byte_ff <= byte_ff + 2'd1;
      end
   end

   assign rf_we   = cmd.finish && wr_ff && (widx_ff != '0);
   assign rf_widx = widx_ff;
   assign rf_wval = res_ff;

   logic [71:0] out_ff;
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (rf_we) out_ff <= {res_ff, widx_ff, 1'b1, status_ff, npc_ff};
         else out_ff <= {32'd0, 5'd0, 1'b0, status_ff, npc_ff};
      end
   end
   assign rsp_word = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (op == OP_DIV))
      else $error("divider stepped for another operation");
   assert property (@(posedge clock) disable iff (reset)
      mwe |-> stat.is_mem)
      else $error("memory write outside a store");
   assert property (@(posedge clock) disable iff (reset)
      rf_we |-> rf_widx != '0)
      else $error("write to register zero");

endmodule

FILE: sv/mips_subset_execute_unit_core.sv
// Executes one decoded instruction of a MIPS32 integer subset per input word
// and returns one result word (next pc, status, register write). Memory
// operations step byte by byte through the single byte-wide memory port,
// and a divide runs on the one-bit-per-cycle divider. Configuration writes
// load pc, sp or gp at once.
module mips_subset_execute_unit_core
   import mseu_pkg::*;
#(
   parameter int MEM_BYTES = MemBytesDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // operation, source_reg, target_reg, dest_reg, immediate, jump_target
   input  logic [63:0]        req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // next_pc, status, reg_written, written_index, written_value
   output logic [71:0]        rsp_tdata,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [31:0]        csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   mseu_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .stat, .cmd
   );

   mseu_datapath #(.MemBytes(MEM_BYTES)) u_dp (
      .clock, .reset, .cmd, .stat, .req_word(req_tdata),
      .csr_we, .csr_index, .csr_wdata, .rsp_word(rsp_tdata)
   );

endmodule

FILE: test/mips_subset_execute_unit_core_tb.sv
module mips_subset_execute_unit_core_tb;
   import mseu_pkg::*;

   typedef struct packed {
      logic [31:0] written_value;
      logic [4:0]  written_index;
      logic        reg_written;
      logic [1:0]  status;
      logic [31:0] next_pc;
   } outcome_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [63:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [71:0] rsp_tdata;
   logic csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [31:0] csr_wdata;

   // Shadow of the architectural state, advanced as each word is queued.
   logic [31:0] gpr [RegCount];
   logic [31:0] pc_q;
   logic [31:0] hi_q;
   logic [31:0] lo_q;
   logic [7:0] data_mem [int];
   int byte_addrs [$];
   int word_bases [$];

   logic [63:0] instr_queue [$];
   outcome_type expected_outcomes [$];
   int src_idle_pct;
   int snk_idle_pct;
   int errors;

   mips_subset_execute_unit_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] read_gpr(logic [4:0] idx);
      return (idx == 5'd0) ? 32'd0 : gpr[idx];
   endfunction

   function automatic logic [31:0] sign_ext16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic int byte_slot(logic [31:0] addr);
      return int'(addr % 32'd65536);
   endfunction

   function automatic outcome_type execute_instr(logic [4:0] op, logic [4:0] rs_idx,
                                                 logic [4:0] rt_idx, logic [4:0] rd_idx,
                                                 logic [15:0] imm, logic [25:0] tgt);
      outcome_type res;
      logic [31:0] rs;
      logic [31:0] rt;
      logic [31:0] simm;
      logic [31:0] addr;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] quo;
      logic [31:0] rem;
      logic [63:0] prod;
      logic wr;
      rs = read_gpr(rs_idx);
      rt = read_gpr(rt_idx);
      simm = sign_ext16(imm);
      addr = rs + simm;
      wr = 1'b0;
      res = '0;
      res.next_pc = pc_q + 32'd4;
      res.status = ST_OK;
      case (op)
         OP_NOOP: ;
         OP_ADD, OP_ADDU: begin
            wr = 1'b1; res.written_index = rd_idx; res.written_value = rs + rt;
         end
         OP_ADDI, OP_ADDIU: begin
            wr = 1'b1; res.written_index = rt_idx; res.written_value = rs + simm;
         end
         OP_SUB: begin
            wr = 1'b1; res.written_index = rd_idx; res.written_value = rs - rt;
         end
         OP_DIV: begin
            if (rt != 32'd0) begin
               ma = rs[31] ? -rs : rs;
               mb = rt[31] ? -rt : rt;
               quo = ma / mb;
               rem = ma % mb;
               lo_q = (rs[31] != rt[31]) ? -quo : quo;
               hi_q = rs[31] ? -rem : rem;
            end
         end
         OP_MULT: begin
            prod = $signed({{32{rs[31]}}, rs}) * $signed({{32{rt[31]}}, rt});
            lo_q = prod[31:0];
            hi_q = prod[63:32];
         end
         OP_J: res.next_pc = ((pc_q + 32'd4) & JumpRegionMask) | {4'd0, tgt, 2'd0};
         OP_SYSCALL: begin
            if (read_gpr(REG_V0) == ExitCode) begin
               res.status = ST_TERM;
               res.next_pc = pc_q;
            end else begin
               res.status = ST_BADSYS;
            end
         end
         OP_ORI: begin
            wr = 1'b1; res.written_index = rt_idx; res.written_value = rs | {16'd0, imm};
         end
         OP_AND: begin
            wr = 1'b1; res.written_index = rd_idx; res.written_value = rs & rt;
         end
         OP_BEQ: if (rs == rt) res.next_pc = pc_q + 32'd4 + (simm << 2);
         OP_MFHI: begin
            wr = 1'b1; res.written_index = rd_idx; res.written_value = hi_q;
         end
         OP_MFLO: begin
            wr = 1'b1; res.written_index = rd_idx; res.written_value = lo_q;
         end
         OP_LUI: begin
            wr = 1'b1; res.written_index = rt_idx; res.written_value = {imm, 16'd0};
         end
         OP_LB: begin
            wr = 1'b1; res.written_index = rt_idx;
            res.written_value = {{24{data_mem[byte_slot(addr)][7]}}, data_mem[byte_slot(addr)]};
         end
         OP_SB: begin
            data_mem[byte_slot(addr)] = rt[7:0];
            byte_addrs.push_back(byte_slot(addr));
         end
         OP_LW: begin
            wr = 1'b1; res.written_index = rt_idx;
            for (int k = 0; k < 4; k++)
               res.written_value = {res.written_value[23:0], data_mem[byte_slot(addr + k)]};
         end
         OP_SW: begin
            for (int k = 0; k < 4; k++) begin
               data_mem[byte_slot(addr + k)] = rt[31 - 8*k -: 8];
               byte_addrs.push_back(byte_slot(addr + k));
            end
            word_bases.push_back(byte_slot(addr));
         end
         default: begin
            res.status = ST_UNSUP;
            res.next_pc = pc_q;
         end
      endcase
      if (wr && res.written_index != 5'd0) begin
         res.reg_written = 1'b1;
         gpr[res.written_index] = res.written_value;
      end else begin
         res.written_index = '0;
         res.written_value = '0;
      end
      pc_q = res.next_pc;
      return res;
   endfunction

   task automatic queue_instr(logic [4:0] op, logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                              logic [15:0] imm, logic [25:0] tgt);
      expected_outcomes.push_back(execute_instr(op, rs, rt, rd, imm, tgt));
      instr_queue.push_back({2'b00, tgt, imm, rd, rt, rs, op});
   endtask

   task automatic queue_random_instr();
      logic [4:0] op;
      logic [4:0] rs;
      logic [31:0] target_addr;
      op = ($urandom_range(0, 99) < 5) ? 5'($urandom_range(20, 31)) : 5'($urandom_range(0, 19));
      rs = 5'($urandom);
      // Loads are steered onto bytes that were already stored.
      if (op == OP_LB && byte_addrs.size() == 0) op = OP_SB;
      if (op == OP_LW && word_bases.size() == 0) op = OP_SW;
      if (op == OP_SYSCALL && $urandom_range(0, 2) == 0)
         queue_instr(OP_ORI, 5'd0, REG_V0, 5'($urandom), 16'd10, 26'($urandom));
      if (op == OP_LB || op == OP_LW) begin
         target_addr = (op == OP_LB) ? byte_addrs[$urandom_range(0, byte_addrs.size() - 1)]
                                     : word_bases[$urandom_range(0, word_bases.size() - 1)];
         queue_instr(op, rs, 5'($urandom), 5'($urandom), 16'(target_addr - read_gpr(rs)),
                     26'($urandom));
      end else begin
         queue_instr(op, rs, 5'($urandom), 5'($urandom), 16'($urandom), 26'($urandom));
      end
   endtask

   task automatic write_csr(logic [CsrIdxW-1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_START_PC) pc_q = value;
      else if (idx == CSR_SP_INIT) gpr[REG_SP] = value;
      else gpr[REG_GP] = value;
   endtask

   task automatic wait_drained();
      wait (instr_queue.size() == 0 && !req_tvalid && expected_outcomes.size() == 0);
      // A store returns its word only after the last byte step; give the divider room too.
      repeat (50) @(posedge clock);
   endtask

   // Driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (instr_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= instr_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_outcomes.size() == 0) begin
               $error("unexpected result word %h", got);
               errors++;
            end else begin
               want = expected_outcomes.pop_front();
               if (got.next_pc !== want.next_pc) begin
                  $error("next_pc expected %h actual %h", want.next_pc, got.next_pc);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, got.status);
                  errors++;
               end
               if (got.reg_written !== want.reg_written) begin
                  $error("reg_written expected %0d actual %0d",
                         want.reg_written, got.reg_written);
                  errors++;
               end
               if (got.written_index !== want.written_index) begin
                  $error("written_index expected %0d actual %0d",
                         want.written_index, got.written_index);
                  errors++;
               end
               if (got.written_value !== want.written_value) begin
                  $error("written_value expected %h actual %h",
                         want.written_value, got.written_value);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      #50_000_000;
      $display("mips_subset_execute_unit_core_tb NOT OK");
      $finish;
   end

   initial begin
      errors = 0;
      src_idle_pct = 30;
      snk_idle_pct = 84;
      reset = 1'b1;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = CSR_START_PC;
      csr_wdata = '0;
      for (int i = 0; i < RegCount; i++) gpr[i] = '0;
      pc_q = '0;
      hi_q = '0;
      lo_q = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 0) begin
            write_csr(CSR_START_PC, 32'd0);
            write_csr(CSR_SP_INIT, 32'hFFFF_FFFF);
            write_csr(CSR_GP_INIT, 32'd0);
         end else if (phase == 1) begin
            src_idle_pct = 84;
            snk_idle_pct = 30;
            write_csr(CSR_START_PC, 32'hFFFF_FFFC);
            write_csr(CSR_SP_INIT, $urandom);
            write_csr(CSR_GP_INIT, 32'hFFFF_FFFF);
         end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
            write_csr(CSR_START_PC, $urandom);
            write_csr(CSR_SP_INIT, 32'd0);
            write_csr(CSR_GP_INIT, $urandom);
         end
         if (phase == 0) begin
            queue_instr(OP_NOOP, 5'd0, 5'd0, 5'd0, 16'd0, 26'd0);
            queue_instr(OP_LUI, 5'd0, 5'd3, 5'd0, 16'h8000, 26'd0);
            queue_instr(OP_ADDI, 5'd0, 5'd4, 5'd0, 16'hFFFF, 26'd0);
            queue_instr(OP_ADDIU, 5'd0, 5'd5, 5'd0, 16'h7FFF, 26'd0);
            queue_instr(OP_ADD, 5'd3, 5'd4, 5'd6, 16'd0, 26'd0);
            queue_instr(OP_ADDU, 5'd3, 5'd3, 5'd0, 16'd0, 26'd0);  // write to r0 is dropped
            queue_instr(OP_SUB, 5'd3, 5'd5, 5'd7, 16'd0, 26'd0);
            queue_instr(OP_AND, 5'd4, 5'd5, 5'd8, 16'd0, 26'd0);
            queue_instr(OP_ORI, 5'd3, 5'd9, 5'd0, 16'hFFFF, 26'd0);
            // Most negative over minus one, then a division by zero that keeps hi and lo.
            queue_instr(OP_DIV, 5'd3, 5'd4, 5'd0, 16'd0, 26'd0);
            queue_instr(OP_MFHI, 5'd0, 5'd0, 5'd10, 16'd0, 26'd0);
            queue_instr(OP_DIV, 5'd5, 5'd0, 5'd0, 16'd0, 26'd0);
            queue_instr(OP_MFLO, 5'd0, 5'd0, 5'd11, 16'd0, 26'd0);
            queue_instr(OP_DIV, 5'd7, 5'd5, 5'd0, 16'd0, 26'd0);
            queue_instr(OP_MFHI, 5'd0, 5'd0, 5'd12, 16'd0, 26'd0);
            queue_instr(OP_MULT, 5'd3, 5'd3, 5'd0, 16'd0, 26'd0);
            queue_instr(OP_MFHI, 5'd0, 5'd0, 5'd13, 16'd0, 26'd0);
            // A word at the top of memory wraps around to address zero.
            queue_instr(OP_SW, 5'd0, 5'd9, 5'd0, 16'hFFFE, 26'd0);
            queue_instr(OP_LW, 5'd0, 5'd14, 5'd0, 16'hFFFE, 26'd0);
            queue_instr(OP_SB, 5'd0, 5'd4, 5'd0, 16'h0010, 26'd0);
            queue_instr(OP_LB, 5'd0, 5'd15, 5'd0, 16'h0010, 26'd0);
            queue_instr(OP_BEQ, 5'd0, 5'd0, 5'd0, 16'h8000, 26'd0);
            queue_instr(OP_BEQ, 5'd3, 5'd0, 5'd0, 16'h7FFF, 26'd0);
            queue_instr(OP_J, 5'd0, 5'd0, 5'd0, 16'd0, 26'h3FF_FFFF);
            queue_instr(OP_ORI, 5'd0, REG_V0, 5'd0, 16'd10, 26'd0);
            queue_instr(OP_SYSCALL, 5'd0, 5'd0, 5'd0, 16'd0, 26'd0);
            queue_instr(OP_ORI, 5'd0, REG_V0, 5'd0, 16'd11, 26'd0);
            queue_instr(OP_SYSCALL, 5'd0, 5'd0, 5'd0, 16'd0, 26'd0);
            queue_instr(5'd31, 5'd31, 5'd31, 5'd31, 16'hFFFF, 26'h3FF_FFFF);
         end
         for (int n = 0; n < 230; n++) queue_random_instr();
         wait_drained();
      end

      if (errors == 0) begin
         $display("mips_subset_execute_unit_core_tb OK");
      end else begin
         $display("mips_subset_execute_unit_core_tb NOT OK");
      end
      $finish;
   end

endmodule
